[rtl/sic_pkg.sv]
// Package for the segment intersection block.
// Holds the tag that travels with each transaction down the pipeline; no dependencies.
`default_nettype none

package sic_pkg;

    // Control tag carried beside the payload out of the front end and through every divider cell.
    typedef struct packed {
        logic valid;
        logic hit;
    } sic_tag_t;

endpackage

`default_nettype wire

[rtl/sic_req_if.sv]
// Request channel: two segments as signed coordinates, valid/ready handshake.
// No dependencies.
`default_nettype none

interface sic_req_if #(
    parameter int COORD_WIDTH = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] a1_x;
    logic signed [COORD_WIDTH-1:0] a1_y;
    logic signed [COORD_WIDTH-1:0] a2_x;
    logic signed [COORD_WIDTH-1:0] a2_y;
    logic signed [COORD_WIDTH-1:0] b1_x;
    logic signed [COORD_WIDTH-1:0] b1_y;
    logic signed [COORD_WIDTH-1:0] b2_x;
    logic signed [COORD_WIDTH-1:0] b2_y;

    modport source (
        output valid, a1_x, a1_y, a2_x, a2_y, b1_x, b1_y, b2_x, b2_y,
        input  ready
    );

    modport sink (
        input  valid, a1_x, a1_y, a2_x, a2_y, b1_x, b1_y, b2_x, b2_y,
        output ready
    );
endinterface

`default_nettype wire

[rtl/sic_rsp_if.sv]
// Response channel: hit flag and intersection parameter, valid/ready handshake.
// No dependencies.
`default_nettype none

interface sic_rsp_if #(
    parameter int FRACTION_BITS = 16
);
    logic                   valid;
    logic                   ready;
    logic                   hit;
    logic [FRACTION_BITS:0] t_fraction;

    modport source (
        output valid, hit, t_fraction,
        input  ready
    );

    modport sink (
        input  valid, hit, t_fraction,
        output ready
    );
endinterface

`default_nettype wire

[rtl/sic_front.sv]
// Front end: differences, cross products, determinants and the range tests.
// Four register stages; depends on sic_pkg and sic_req_if.
`default_nettype none

module sic_front
    import sic_pkg::*;
#(
    parameter int COORD_WIDTH = 16
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    sic_req_if.sink                             req,
    input  wire logic                           down_en,
    output sic_tag_t                            tag,
    output logic     [2*COORD_WIDTH+2:0]        num,
    output logic     [2*COORD_WIDTH+2:0]        den
);
    localparam int DIFF_W = COORD_WIDTH + 1;
    localparam int PROD_W = 2 * DIFF_W;
    localparam int SUM_W  = PROD_W + 1;

    logic en1, en2, en3, en4;
    logic v1_reg, v2_reg, v3_reg, v4_reg;

    logic signed [DIFF_W-1:0] dxa_reg, dya_reg, dxb_reg, dyb_reg, dxab_reg, dyab_reg;
    logic signed [PROD_W-1:0] p0_reg, p1_reg, p2_reg, p3_reg, p4_reg, p5_reg;
    logic signed [PROD_W-1:0] p0_next, p1_next, p2_next, p3_next, p4_next, p5_next;
    logic signed [SUM_W-1:0]  den_reg, tn_reg, un_reg;
    logic signed [SUM_W-1:0]  den_n, tn_n, un_n;
    logic                     hit_next;
    logic                     hit_reg;
    logic        [SUM_W-1:0]  num_reg, dmag_reg;

    // A stage loads when it is empty or its contents move on in the same cycle.
    assign en4       = !v4_reg || down_en;
    assign en3       = !v3_reg || en4;
    assign en2       = !v2_reg || en3;
    assign en1       = !v1_reg || en2;
    assign req.ready = en1;

    assign p0_next = dxa_reg * dyb_reg;
    assign p1_next = dya_reg * dxb_reg;
    assign p2_next = dxab_reg * dyb_reg;
    assign p3_next = dyab_reg * dxb_reg;
    assign p4_next = dxa_reg * dyab_reg;
    assign p5_next = dya_reg * dxab_reg;

    // Normalise to a positive denominator so that both range tests become
    // plain comparisons: 0 <= tn <= den and -den <= un <= 0.
    always_comb
    begin
        if (den_reg[SUM_W-1])
        begin
            den_n = -den_reg;
            tn_n  = -tn_reg;
            un_n  = -un_reg;
        end
        else
        begin
            den_n = den_reg;
            tn_n  = tn_reg;
            un_n  = un_reg;
        end
        hit_next = (den_reg != '0) && !tn_n[SUM_W-1] && (tn_n <= den_n)
                   && (un_n <= $signed(SUM_W'(0))) && (un_n >= -den_n);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (en1)
                v1_reg <= req.valid;
            if (en2)
                v2_reg <= v1_reg;
            if (en3)
                v3_reg <= v2_reg;
            if (en4)
                v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            dxa_reg  <= DIFF_W'(req.a1_x) - DIFF_W'(req.a2_x);
            dya_reg  <= DIFF_W'(req.a1_y) - DIFF_W'(req.a2_y);
            dxb_reg  <= DIFF_W'(req.b1_x) - DIFF_W'(req.b2_x);
            dyb_reg  <= DIFF_W'(req.b1_y) - DIFF_W'(req.b2_y);
            dxab_reg <= DIFF_W'(req.a1_x) - DIFF_W'(req.b1_x);
            dyab_reg <= DIFF_W'(req.a1_y) - DIFF_W'(req.b1_y);
        end
        if (en2)
        begin
            p0_reg <= p0_next;
            p1_reg <= p1_next;
            p2_reg <= p2_next;
            p3_reg <= p3_next;
            p4_reg <= p4_next;
            p5_reg <= p5_next;
        end
        if (en3)
        begin
            den_reg <= SUM_W'(p0_reg) - SUM_W'(p1_reg);
            tn_reg  <= SUM_W'(p2_reg) - SUM_W'(p3_reg);
            un_reg  <= SUM_W'(p4_reg) - SUM_W'(p5_reg);
        end
        if (en4)
        begin
            hit_reg  <= hit_next;
            num_reg  <= tn_n;
            dmag_reg <= den_n;
        end
    end

    assign tag.valid = v4_reg;
    assign tag.hit   = hit_reg;
    assign num       = num_reg;
    assign den       = dmag_reg;

endmodule

`default_nettype wire

[rtl/sic_div_cell.sv]
// One restoring division step: yields one quotient bit and passes the remainder on.
// Depends on sic_pkg.
`default_nettype none

module sic_div_cell
    import sic_pkg::*;
#(
    parameter int  REM_W   = 35,
    parameter int  Q_W     = 17,
    parameter bit  NO_SHIFT = 1'b0
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire sic_tag_t         tag_in,
    input  wire logic [REM_W-1:0] rem_in,
    input  wire logic [REM_W-1:0] den_in,
    input  wire logic [Q_W-1:0]   q_in,
    input  wire logic             down_en,
    output logic                  en,
    output sic_tag_t              tag_out,
    output logic      [REM_W-1:0] rem_out,
    output logic      [REM_W-1:0] den_out,
    output logic      [Q_W-1:0]   q_out
);
    logic             valid_reg;
    logic             hit_reg;
    logic [REM_W-1:0] rem_reg, den_reg, rem_next, rem_s;
    logic [Q_W-1:0]   q_reg, q_next;
    logic             ge;

    assign en = !valid_reg || down_en;

    // The remainder stays below twice the divisor, so the shift cannot overflow.
    always_comb
    begin
        rem_s    = NO_SHIFT ? rem_in : {rem_in[REM_W-2:0], 1'b0};
        ge       = rem_s >= den_in;
        rem_next = ge ? rem_s - den_in : rem_s;
        q_next   = {q_in[Q_W-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= tag_in.valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hit_reg <= tag_in.hit;
            rem_reg <= rem_next;
            den_reg <= den_in;
            q_reg   <= q_next;
        end
    end

    assign tag_out.valid = valid_reg;
    assign tag_out.hit   = hit_reg;
    assign rem_out       = rem_reg;
    assign den_out       = den_reg;
    assign q_out         = q_reg;

endmodule

`default_nettype wire

[rtl/segment_intersection_param.sv]
// Top level of the segment intersection block: front end, divider cell row, output register.
// Depends on sic_pkg, sic_req_if, sic_rsp_if, sic_front and sic_div_cell.
//
// Usage: each transaction on req carries two segments, A from a1 to a2 and B from b1 to b2,
// as signed COORD_WIDTH-bit coordinates. For every request one transaction leaves on rsp:
// hit is 1 when the segments meet in a single point (endpoint touches included), and
// t_fraction then gives the position along A as an unsigned fraction with FRACTION_BITS
// fraction bits, truncated; on a miss t_fraction is 0. Parallel, collinear and zero-length
// segments always miss.
// From acceptance to rsp.valid a transaction passes four front-end stages,
// FRACTION_BITS + 1 division cells (one quotient bit each) and the output register.
// Throughput is one transaction per cycle while rsp.ready stays high, set by the row of
// division cells, each of which takes a new remainder every cycle unless the row is stalled.
// Reset empties every stage; no response is pending afterwards. When the receiver holds
// rsp.ready low, the result waits in the output register while the stages behind it keep
// filling; req.ready falls only once every stage holds a transaction.

`default_nettype none

module segment_intersection_param
    import sic_pkg::*;
#(
    parameter int COORD_WIDTH   = 16,
    parameter int FRACTION_BITS = 16
) (
    input  wire logic clk,
    input  wire logic rst_n,
    sic_req_if.sink   req,
    sic_rsp_if.source rsp
);
    localparam int REM_W  = 2 * COORD_WIDTH + 3;
    localparam int Q_W    = FRACTION_BITS + 1;
    localparam int NCELLS = FRACTION_BITS + 1;

    sic_tag_t         tag_c [0:NCELLS];
    logic [REM_W-1:0] rem_c [0:NCELLS];
    logic [REM_W-1:0] den_c [0:NCELLS];
    logic [Q_W-1:0]   q_c   [0:NCELLS];
    logic             en_c  [0:NCELLS];

    logic             out_valid_reg;
    logic             out_hit_reg;
    logic [Q_W-1:0]   out_t_reg;

    sic_front #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .down_en (en_c[0]),
        .tag     (tag_c[0]),
        .num     (rem_c[0]),
        .den     (den_c[0])
    );

    assign q_c[0] = '0;

    for (genvar i = 0; i < NCELLS; i++)
    begin : g_cell
        sic_div_cell #(
            .REM_W    (REM_W),
            .Q_W      (Q_W),
            .NO_SHIFT (i == 0)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .tag_in  (tag_c[i]),
            .rem_in  (rem_c[i]),
            .den_in  (den_c[i]),
            .q_in    (q_c[i]),
            .down_en (en_c[i+1]),
            .en      (en_c[i]),
            .tag_out (tag_c[i+1]),
            .rem_out (rem_c[i+1]),
            .den_out (den_c[i+1]),
            .q_out   (q_c[i+1])
        );
    end

    assign en_c[NCELLS] = !out_valid_reg || rsp.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en_c[NCELLS])
            out_valid_reg <= tag_c[NCELLS].valid;
    end

    // On a miss the divider ran on meaningless operands, so its quotient is dropped here.
    always_ff @(posedge clk)
    begin
        if (en_c[NCELLS])
        begin
            out_hit_reg <= tag_c[NCELLS].hit;
            out_t_reg   <= tag_c[NCELLS].hit ? q_c[NCELLS] : '0;
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.hit        = out_hit_reg;
    assign rsp.t_fraction = out_t_reg;

endmodule

`default_nettype wire
